// File: hw/rtl/pres24_pkg.sv
// shared types, constants and round functions for the 24-bit present encryptor
`default_nettype none

package pres24_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int BLOCK_W     = 24;
    localparam int KEY_W       = 80;
    localparam int MKEY_W      = 24;
    localparam int RC_W        = 5;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [RC_W-1:0]    rc_t;

    // one item in flight between cells
    typedef struct packed {
        logic   valid;
        block_t state;
        key_t   key;
    } stage_t;

    localparam logic [3:0] SBOX [16] = '{
        4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
        4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2
    };

    // destination of each state bit, 6*j mod 23 with the top bit fixed
    localparam int PERM_DST [BLOCK_W] = '{
        0, 6, 12, 18, 1, 7, 13, 19, 2, 8, 14, 20,
        3, 9, 15, 21, 4, 10, 16, 22, 5, 11, 17, 23
    };

    function automatic block_t sub_layer(input block_t s);
        block_t r;
        r = '0;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic block_t perm_layer(input block_t s);
        block_t r;
        r = '0;
        for (int j = 0; j < BLOCK_W; j++) begin
            r[PERM_DST[j]] = s[j];
        end
        return r;
    endfunction

    function automatic block_t round_key(input key_t k);
        return k[39:16];
    endfunction

    function automatic key_t key_update(input key_t k, input rc_t rc);
        key_t n;
        n = {k[18:0], k[79:19]};
        n[79:76] = SBOX[n[79:76]];
        n[19:15] = n[19:15] ^ rc;
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pres24_cell.sv
// one cipher round with its key schedule step, registered
`default_nettype none

module pres24_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pres24_pkg::rc_t   rc,
    input  wire pres24_pkg::stage_t prev,
    output logic                   prev_ready,
    output pres24_pkg::stage_t     cur,
    input  wire logic              next_ready
);

    logic                 valid_reg;
    logic                 valid_next;
    pres24_pkg::block_t   state_reg;
    pres24_pkg::block_t   state_next;
    pres24_pkg::key_t     key_reg;
    pres24_pkg::key_t     key_next;

    // cell takes a new item when empty or when its item moves on
    assign prev_ready = !valid_reg || next_ready;

    always_comb
    begin
        valid_next = prev_ready ? prev.valid : valid_reg;
        state_next = pres24_pkg::perm_layer(pres24_pkg::sub_layer(
                         prev.state ^ pres24_pkg::round_key(prev.key)));
        key_next   = pres24_pkg::key_update(prev.key, rc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_ready && prev.valid)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign cur.valid = valid_reg;
    assign cur.state = state_reg;
    assign cur.key   = key_reg;

endmodule

`default_nettype wire

// File: hw/rtl/present24_block_encrypt.sv
// top level: 24-bit present encryptor, one round cell per round and an output register
//
// channel   signals                         direction
// input     in_valid, in_stall, plaintext    plaintext in
// output    out_valid, out_stall, ciphertext ciphertext out
// config    cfg_valid, cfg_ready, cfg_data   master key write
//
// one block per cycle while the output is not stalled; each block passes through every
// round cell in turn, then the output register, which applies the final key xor
// each cell carries its block and its 80-bit key register to the next cell
// reset clears all valid bits and the master key
// a stalled output lets empty cells upstream keep filling
`default_nettype none

module present24_block_encrypt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [23:0] plaintext,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [23:0]      ciphertext,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data
);

    localparam int N = pres24_pkg::ROUND_COUNT;

    pres24_pkg::stage_t chain [N+1];
    logic               ready [N+1];

    logic [pres24_pkg::MKEY_W-1:0] master_key_reg;
    logic [pres24_pkg::MKEY_W-1:0] master_key_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    pres24_pkg::block_t            ciphertext_reg;
    pres24_pkg::block_t            ciphertext_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        master_key_next = (cfg_valid && cfg_ready) ? cfg_data : master_key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_key_reg <= '0;
        end
        else
        begin
            master_key_reg <= master_key_next;
        end
    end

    // master key sits in the top of the key register
    assign chain[0].valid = in_valid;
    assign chain[0].state = plaintext;
    assign chain[0].key   = {master_key_reg,
                             {(pres24_pkg::KEY_W - pres24_pkg::MKEY_W){1'b0}}};
    assign in_stall = !ready[0];

    for (genvar i = 0; i < N; i++) begin : g_cell
        pres24_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .rc         (pres24_pkg::rc_t'(i + 1)),
            .prev       (chain[i]),
            .prev_ready (ready[i]),
            .cur        (chain[i+1]),
            .next_ready (ready[i+1])
        );
    end

    assign ready[N] = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = ready[N] ? chain[N].valid : out_valid_reg;
        ciphertext_next = chain[N].state ^ pres24_pkg::round_key(chain[N].key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[N] && chain[N].valid)
        begin
            ciphertext_reg <= ciphertext_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ciphertext = ciphertext_reg;

endmodule

`default_nettype wire

// File: tb/sv/present24_block_encrypt_test.sv
// self-checking testbench for the 24-bit present block encryptor
module present24_block_encrypt_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int PHASE_BLOCKS   = 250;
    localparam int PHASE_COUNT    = 5;
    localparam int SETTLE_CYCLES  = pres24_pkg::ROUND_COUNT + 4;

    localparam logic [3:0] PRESENT_SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    typedef struct packed {
        logic [23:0]        key;
        pres24_pkg::block_t pt;
    } key_block_t;

    // rows grouped by key, a new key is loaded only between groups
    localparam int DIRECTED_ROWS = 20;
    localparam key_block_t DIRECTED [DIRECTED_ROWS] = '{
        '{24'h000000, 24'h000000},
        '{24'h000000, 24'hFFFFFF},
        '{24'h000000, 24'h000001},
        '{24'h000000, 24'h800000},
        '{24'h000000, 24'h555555},
        '{24'h000000, 24'hAAAAAA},
        '{24'h000000, 24'h012345},
        '{24'h000000, 24'h6789AB},
        '{24'h000000, 24'hCDEF00},
        '{24'hFFFFFF, 24'h000000},
        '{24'hFFFFFF, 24'hFFFFFF},
        '{24'hFFFFFF, 24'h123456},
        '{24'hFFFFFF, 24'h0F0F0F},
        '{24'h000000, 24'hFFFFFF},
        '{24'h000000, 24'h7FFFFF},
        '{24'h800000, 24'h000000},
        '{24'h000001, 24'h000000},
        '{24'h000001, 24'hFFFFFF},
        '{24'hA5C3F0, 24'h5A3C0F},
        '{24'h5A3C0F, 24'hA5C3F0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    pres24_pkg::block_t plaintext = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pres24_pkg::block_t ciphertext;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [23:0]        cfg_data = '0;

    logic [23:0]        key_now = '0;
    pres24_pkg::block_t pending_ciphertext [$];
    pres24_pkg::block_t ct_want;
    int                 err_count = 0;
    int                 free_left = 0;
    int                 stall_left = 0;

    present24_block_encrypt u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plaintext  (plaintext),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ciphertext (ciphertext),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic pres24_pkg::block_t present24_encrypt(
        input pres24_pkg::block_t pt,
        input logic [23:0]        mkey
    );
        pres24_pkg::key_t   kreg;
        pres24_pkg::block_t st;
        pres24_pkg::block_t moved;
        kreg = {mkey, 56'd0};
        st = pt;
        for (int r = 1; r <= pres24_pkg::ROUND_COUNT; r++)
        begin
            st = st ^ kreg[39:16];
            for (int n = 0; n < 6; n++)
            begin
                st[4*n +: 4] = PRESENT_SBOX[st[4*n +: 4]];
            end
            moved = '0;
            for (int j = 0; j < 24; j++)
            begin
                moved[(j == 23) ? 23 : (6 * j) % 23] = st[j];
            end
            st = moved;
            // rotate left by 61, s-box on the top nibble, round counter into bits 19..15
            kreg = {kreg[18:0], kreg[79:19]};
            kreg[79:76] = PRESENT_SBOX[kreg[79:76]];
            kreg[19:15] = kreg[19:15] ^ pres24_pkg::rc_t'(r);
        end
        return st ^ kreg[39:16];
    endfunction

    task automatic send_block(input pres24_pkg::block_t pt);
        plaintext <= pt;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_ciphertext.push_back(present24_encrypt(pt, key_now));
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop sending, let every outstanding block come out, then idle for the SETTLE_CYCLES margin
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_ciphertext.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_key(input logic [23:0] k);
        cfg_data  <= k;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        key_now = k;
    endtask

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_ciphertext.size() == 0)
            begin
                $error("ciphertext %06h with no block outstanding", ciphertext);
                err_count++;
            end
            else
            begin
                ct_want = pending_ciphertext.pop_front();
                if (ciphertext !== ct_want)
                begin
                    $error("ciphertext mismatch: expected %06h, actual %06h",
                           ct_want, ciphertext);
                    err_count++;
                end
            end
        end
        if (free_left > 0)
        begin
            free_left--;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            free_left  = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 25);
            stall_left = $urandom_range(1, 10);
            out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[present24_block_encrypt] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int                 sent;
        int                 burst;
        logic [23:0]        k;
        logic [3:0]         nib;
        pres24_pkg::block_t pt;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the key left by reset
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].key != key_now)
            begin
                settle();
                load_key(DIRECTED[i].key);
            end
            send_block(DIRECTED[i].pt);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1:       k = 24'hFFFFFF;
                3:       k = 24'h000000;
                default: k = 24'($urandom);
            endcase
            settle();
            load_key(k);
            sent = 0;
            while (sent < PHASE_BLOCKS)
            begin
                burst = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 40);
                for (int b = 0; b < burst && sent < PHASE_BLOCKS; b++)
                begin
                    // hold off once mid-phase until the pipeline is empty
                    if (phase == 2 && sent == PHASE_BLOCKS / 2)
                        settle();
                    nib = 4'($urandom_range(0, 15));
                    case ($urandom_range(0, 9))
                        6:       pt = 24'h000001 << $urandom_range(0, 23);
                        7:       pt = ~(24'h000001 << $urandom_range(0, 23));
                        8:       pt = {6{nib}};
                        9:       pt = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                        default: pt = 24'($urandom);
                    endcase
                    send_block(pt);
                    sent++;
                end
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
            end
        end

        settle();
        if (err_count == 0 && pending_ciphertext.size() == 0)
            $display("[present24_block_encrypt] OK");
        else
            $display("[present24_block_encrypt] ERROR");
        $finish;
    end
endmodule
